@@ hdl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped-term PID corrector
// Command and status bundles between controller and datapath, register
// indexes and sizing of the reciprocal divide by the sample rate.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int RATE_W    = 16;
  localparam int DIV_W     = 48;
  localparam int HALF_W    = DIV_W / 2;
  localparam int ACC_W     = 2 * DIV_W + RATE_W + 1;
  localparam int MAC_STEPS = 4;
  localparam int STEP_W    = 2;
  localparam int CFG_W     = 31;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_KP_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_P_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] REG_I_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_D_LIMIT = 3'd5;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_P    = 3'd1,
    MUL_I    = 3'd2,
    MUL_DA   = 3'd3,
    MUL_DL   = 3'd4,
    MUL_DH   = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     take_p;
    logic     div_start;
    logic     take_a;
    logic     take_dlo;
    logic     take_d;
    logic     take_i;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/pid_corrector_clamped_terms.sv @@
// ----------------------------------------------------------------------------
// pid_corrector_clamped_terms: PID corrector with separately clamped terms
// One signed Q16.16 error sample in, one correction with its P, I and D
// parts out, each term clamped symmetrically to its limit register.
//
// Input channel: error_sample transfers when in_valid is high and in_stall
// is low. in_stall is high from the transfer until the result has been
// loaded into the output register.
// Output channel: correction, p_term, i_term and d_term transfer when
// out_valid is high and out_stall is low; a stalled result holds, and the
// next sample is taken while it waits.
// The P and I products come first, then the reciprocal multiply divides
// the integral increment by SAMPLE_RATE beside the D passes; the integral
// is then updated and the output register loaded.
// Configuration: cfg_write with cfg_index and cfg_data writes a register at
// once; write only while no item is in flight. Unknown indexes are dropped.
// Reset: gains clear, limits go to full scale, integral and previous error
// clear, the output register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_corrector_clamped_terms import pidc_pkg::*; #(
  parameter int SAMPLE_RATE = 250
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] error_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      correction,
  output logic signed [31:0]      p_term,
  output logic signed [31:0]      i_term,
  output logic signed [31:0]      d_term
);

  cmd_t    cmd;
  status_t status;

  pidc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pidc_dp #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_sample (error_sample),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .correction   (correction),
    .p_term       (p_term),
    .i_term       (i_term),
    .d_term       (d_term)
  );

endmodule

`default_nettype wire

@@ hdl/pidc_div.sv @@
// ----------------------------------------------------------------------------
// pidc_div: divide by the fixed sample rate through a reciprocal multiply
// The dividend is multiplied by a rounded-up reciprocal of the divisor in
// four half-width partial products, one a cycle, summed into a wide
// accumulator; the quotient is a fixed slice of the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_div import pidc_pkg::*; #(
  parameter logic [RATE_W-1:0] DIVISOR = 16'd250
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  output logic                  busy,
  output logic [DIV_W-1:0]      quotient
);

  localparam int SHIFT = DIV_W + $clog2(DIVISOR);
  localparam logic [ACC_W-1:0] RECIP =
    ((ACC_W'(1) << SHIFT) + ACC_W'(DIVISOR) - ACC_W'(1)) / ACC_W'(DIVISOR);
  localparam logic [HALF_W:0]   RECIP_HI = RECIP[2*HALF_W:HALF_W];
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];

  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  x;
  logic [ACC_W-1:0]  acc;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W:0]   mul_b;
  logic [2*HALF_W:0] pp;
  logic [ACC_W-1:0]  addend;

  always_comb begin
    mul_a = step[1] ? x[DIV_W-1:HALF_W] : x[HALF_W-1:0];
    mul_b = step[0] ? RECIP_HI : {1'b0, RECIP_LO};
    pp    = mul_a * mul_b;
    unique case (step)
      2'd0: begin
        addend = ACC_W'(pp);
      end
      2'd1, 2'd2: begin
        addend = ACC_W'(pp) << HALF_W;
      end
      default: begin
        addend = ACC_W'(pp) << DIV_W;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(MAC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + addend;
    end
  end

  assign quotient = acc[SHIFT +: DIV_W];

endmodule

`default_nettype wire

@@ hdl/pidc_dp.sv @@
// ----------------------------------------------------------------------------
// pidc_dp: datapath of the clamped-term PID corrector
// Configuration registers, shared 33x31 multiplier, term clamps, integral
// and previous-error state, divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_dp import pidc_pkg::*; #(
  parameter int SAMPLE_RATE = 250
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic signed [31:0] error_sample,
  input  wire cmd_t               cmd,
  output status_t                 status,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      correction,
  output logic signed [31:0]      p_term,
  output logic signed [31:0]      i_term,
  output logic signed [31:0]      d_term
);

  localparam logic [RATE_W-1:0] RATE = RATE_W'(SAMPLE_RATE);

  logic [CFG_W-1:0]   kp_gain, ki_gain, kd_gain, p_limit, i_limit, d_limit;
  logic               e_neg;
  logic [31:0]        e_mag;
  logic               d_neg;
  logic [32:0]        d_mag;
  logic signed [31:0] previous_error;
  logic signed [31:0] integral_term;
  logic signed [31:0] p_val, d_val;
  logic [63:0]        prod;
  logic [23:0]        a_hi;
  logic [54:0]        d_lo;
  logic [32:0]        opa;
  logic [CFG_W-1:0]   opb;
  logic [32:0]        diff;
  logic [78:0]        d_total;
  logic               div_busy;
  logic [DIV_W-1:0]   quotient;
  logic [32:0]        inc;
  logic signed [34:0] sinc, isum, ilim;
  logic signed [33:0] total;
  logic signed [31:0] sum_sat;

  function automatic logic signed [31:0] sclamp(input logic [62:0] mag, input logic neg,
                                                input logic [CFG_W-1:0] lim);
    logic [31:0] m;
    m = (mag > 63'(lim)) ? {1'b0, lim} : mag[31:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= '0;
      ki_gain <= '0;
      kd_gain <= '0;
      p_limit <= '1;
      i_limit <= '1;
      d_limit <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP_GAIN: kp_gain <= cfg_data;
        REG_KI_GAIN: ki_gain <= cfg_data;
        REG_KD_GAIN: kd_gain <= cfg_data;
        REG_P_LIMIT: p_limit <= cfg_data;
        REG_I_LIMIT: i_limit <= cfg_data;
        REG_D_LIMIT: d_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign diff = {error_sample[31], error_sample} - {previous_error[31], previous_error};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      e_neg <= error_sample[31];
      e_mag <= error_sample[31] ? (~error_sample + 32'd1) : error_sample;
      d_neg <= diff[32];
      d_mag <= diff[32] ? (~diff + 33'd1) : diff;
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_P: begin
        opa = {1'b0, e_mag};
        opb = kp_gain;
      end
      MUL_I: begin
        opa = {1'b0, e_mag};
        opb = ki_gain;
      end
      MUL_DA: begin
        opa = d_mag;
        opb = CFG_W'(RATE);
      end
      MUL_DL: begin
        opa = 33'(prod[23:0]);
        opb = kd_gain;
      end
      MUL_DH: begin
        opa = 33'(a_hi);
        opb = kd_gain;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  assign d_total = 79'(d_lo) + {prod[54:0], 24'b0};

  always_ff @(posedge clk) begin
    if (cmd.take_p) begin
      p_val <= sclamp(63'(prod[63:16]), e_neg, p_limit);
    end
    if (cmd.take_a) begin
      a_hi <= prod[47:24];
    end
    if (cmd.take_dlo) begin
      d_lo <= prod[54:0];
    end
    if (cmd.take_d) begin
      d_val <= sclamp(d_total[78:16], d_neg, d_limit);
    end
  end

  pidc_div #(
    .DIVISOR(RATE)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod[63:16]),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    inc  = (|quotient[DIV_W-1:32]) ? {1'b1, 32'b0} : {1'b0, quotient[31:0]};
    sinc = e_neg ? -$signed({2'b0, inc}) : $signed({2'b0, inc});
    isum = 35'(integral_term) + sinc;
    ilim = $signed({4'b0, i_limit});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_term  <= '0;
      previous_error <= '0;
    end else begin
      if (cmd.load_in) begin
        previous_error <= error_sample;
      end
      if (cmd.take_i) begin
        if (ki_gain == '0) begin
          integral_term <= '0;
        end else if (isum > ilim) begin
          integral_term <= ilim[31:0];
        end else if (isum < -ilim) begin
          integral_term <= 32'(-ilim);
        end else begin
          integral_term <= isum[31:0];
        end
      end
    end
  end

  always_comb begin
    total = 34'(p_val) + 34'(integral_term) + 34'(d_val);
    if (total > 34'sd2147483647) begin
      sum_sat = {1'b0, {31{1'b1}}};
    end else if (total < -34'sd2147483648) begin
      sum_sat = {1'b1, 31'b0};
    end else begin
      sum_sat = total[31:0];
    end
  end

  assign status.div_done = ~div_busy;
  assign status.out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      correction <= sum_sat;
      p_term     <= p_val;
      i_term     <= integral_term;
      d_term     <= d_val;
    end
  end

  a_p_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> p_term != {1'b1, 31'b0})
    else $error("p_term outside symmetric clamp");

  a_i_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> i_term != {1'b1, 31'b0})
    else $error("i_term outside symmetric clamp");

  a_d_sym: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> d_term != {1'b1, 31'b0})
    else $error("d_term outside symmetric clamp");

endmodule

`default_nettype wire

@@ hdl/pidc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pidc_ctrl: sequencer of the clamped-term PID corrector
// Steps the shared multiplier through the P, I and D products, waits for
// the divider, updates the integral and loads the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_ctrl import pidc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_MUL_P    = 9'b000000010,
    ST_MUL_I    = 9'b000000100,
    ST_MUL_DA   = 9'b000001000,
    ST_MUL_DL   = 9'b000010000,
    ST_MUL_DH   = 9'b000100000,
    ST_D_FIN    = 9'b001000000,
    ST_DIV_WAIT = 9'b010000000,
    ST_SUM      = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   take_i_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      take_i_state <= 1'b0;
    end else begin
      state        <= state_next;
      take_i_state <= (state == ST_DIV_WAIT) && status.div_done;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        cmd.mul_sel = MUL_P;
        state_next  = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_sel = MUL_I;
        cmd.take_p  = 1'b1;
        state_next  = ST_MUL_DA;
      end
      ST_MUL_DA: begin
        cmd.mul_sel   = MUL_DA;
        cmd.div_start = 1'b1;
        state_next    = ST_MUL_DL;
      end
      ST_MUL_DL: begin
        cmd.mul_sel = MUL_DL;
        cmd.take_a  = 1'b1;
        state_next  = ST_MUL_DH;
      end
      ST_MUL_DH: begin
        cmd.mul_sel  = MUL_DH;
        cmd.take_dlo = 1'b1;
        state_next   = ST_D_FIN;
      end
      ST_D_FIN: begin
        cmd.take_d = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        cmd.take_i = status.div_done;
        if (status.div_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.load_out = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> status.div_done)
    else $error("divider busy while idle");

  a_sum_after_i: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && $past(state == ST_DIV_WAIT) |-> take_i_state)
    else $error("sum reached without integral update");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && !status.out_free |=> state == ST_SUM)
    else $error("result dropped while output blocked");

endmodule

`default_nettype wire
